### sv/wf3_pkg.sv
// package: shared constants, types and helper functions for the 3x3 window filter
`timescale 1ns / 1ps
package wf3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 24;

    // configuration register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_SMOOTH  = 3'd3;
    localparam logic [2:0] REG_SHARPEN = 3'd4;

    // filter modes
    localparam logic [2:0] MODE_SMOOTH  = 3'd0;
    localparam logic [2:0] MODE_SHARPEN = 3'd1;
    localparam logic [2:0] MODE_MEDIAN  = 3'd2;
    localparam logic [2:0] MODE_MAX     = 3'd3;
    localparam logic [2:0] MODE_MIN     = 3'd4;

    localparam logic [62:0] SMOOTH_RESET = 63'd72624976668147841;

    // window of one channel
    typedef logic [7:0] t_win [9];

    // beat handed from the window stage to the filter stage
    typedef struct packed {
        logic                   border;
        logic                   frame_end;
        logic [9*PIX_W-1:0]     win;
    } t_win_beat;

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    // clamp a signed sum to a byte
    function automatic logic [7:0] clamp8(input logic signed [19:0] s);
        if (s < 0) begin
            return 8'd0;
        end else if (s > 20'sd255) begin
            return 8'd255;
        end else begin
            return s[7:0];
        end
    endfunction

    // median of three
    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max8(min8(a, b), min8(max8(a, b), c));
    endfunction

endpackage

### sv/wf3_if.sv
// interfaces: pixel input, filtered output and configuration write channels
`timescale 1ns / 1ps
interface wf3_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    modport source (output valid, kind, pixel_red, pixel_green, pixel_blue, input ready);
    modport sink   (input valid, kind, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface wf3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered_red;
    logic [7:0] filtered_green;
    logic [7:0] filtered_blue;
    logic       frame_end;
    modport source (output valid, filtered_red, filtered_green, filtered_blue, frame_end,
                    input ready);
    modport sink   (input valid, filtered_red, filtered_green, filtered_blue, frame_end,
                    output ready);
endinterface

interface wf3_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [62:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/wf3_line_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
module wf3_line_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/wf3_filter.sv
// per-channel filter datapath: products, sum tree, divide by nine, sort network
`timescale 1ns / 1ps
module wf3_filter
    import wf3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [2:0]  i_mode,
    input  logic [62:0] i_taps,
    input  logic        i_border,
    input  logic [71:0] i_win,
    output logic [7:0]  o_val
);
    t_win                   v;
    logic signed [15:0]     n_prod [9];
    logic signed [15:0]     r_prod [9];
    logic signed [19:0]     n_sum;
    logic signed [19:0]     r_sum;
    logic [7:0]             r_mx, r_mn, r_md, r_ctr;
    logic [7:0]             r2_mx, r2_mn, r2_md, r2_ctr;
    logic                   r_pass, r2_pass;
    logic [7:0]             n_mx, n_mn, n_md;
    logic [7:0]             lo [3], mi [3], hi [3];
    logic [7:0]             a0, a1, a2, b0, b1, b2, c0, c1, c2;
    logic [35:0]            q_mul;
    logic [14:0]            q;
    logic [7:0]             n_out;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            v[k] = i_win[8*k +: 8];
        end
    end

    // stage one: nine small products and the rank network
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_prod[k] = $signed({8'd0, v[k]}) * $signed({{9{i_taps[7*k+6]}}, i_taps[7*k +: 7]});
        end
        for (int r = 0; r < 3; r++) begin
            a0 = v[3*r]; a1 = v[3*r+1]; a2 = v[3*r+2];
            lo[r] = min8(min8(a0, a1), a2);
            hi[r] = max8(max8(a0, a1), a2);
            mi[r] = med3(a0, a1, a2);
        end
        b0 = max8(max8(lo[0], lo[1]), lo[2]);
        b1 = med3(mi[0], mi[1], mi[2]);
        b2 = min8(min8(hi[0], hi[1]), hi[2]);
        c0 = b0; c1 = b1; c2 = b2;
        n_md = med3(c0, c1, c2);
        n_mx = max8(max8(hi[0], hi[1]), hi[2]);
        n_mn = min8(min8(lo[0], lo[1]), lo[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= n_prod[k];
            end
            r_mx   <= n_mx;
            r_mn   <= n_mn;
            r_md   <= n_md;
            r_ctr  <= v[4];
            r_pass <= i_border || (i_mode > MODE_MIN);
        end
    end

    // stage two: sum of products
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 9; k++) begin
            n_sum = n_sum + 20'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= n_sum;
            r2_mx   <= r_mx;
            r2_mn   <= r_mn;
            r2_md   <= r_md;
            r2_ctr  <= r_ctr;
            r2_pass <= r_pass;
        end
    end

    // stage three: divide by nine by reciprocal multiply (exact for sums below 2^18), select
    always_comb begin
        q_mul = 36'(r_sum[17:0]) * 36'd233017;
        q     = q_mul[35:21];
        n_out = r2_ctr;
        if (!r2_pass) begin
            case (i_mode)
                MODE_SMOOTH: begin
                    if (r_sum < 0) begin
                        n_out = 8'd0;
                    end else begin
                        n_out = (q > 15'd255) ? 8'd255 : q[7:0];
                    end
                end
                MODE_SHARPEN: n_out = clamp8(r_sum);
                MODE_MEDIAN:  n_out = r2_md;
                MODE_MAX:     n_out = r2_mx;
                MODE_MIN:     n_out = r2_mn;
                default:      n_out = r2_ctr;
            endcase
        end
    end

    assign o_val = n_out;
endmodule

### sv/wf3_window.sv
// line stores, position counters and the 3x3 window shift registers
`timescale 1ns / 1ps
module wf3_window
    import wf3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_acc,
    input  logic              i_flush,
    input  logic [23:0]       i_pix,
    input  logic [10:0]       i_w,
    input  logic [11:0]       i_h,
    output logic              o_skip,
    output logic              o_emit,
    output t_win_beat         o_beat
);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    logic [10:0]       r_col;
    logic [11:0]       r_row;
    logic [PW-1:0]     r_pend;
    logic [10:0]       c0, c, oc, n_col;
    logic [11:0]       r0, r, orow, n_row;
    logic [PW-1:0]     n_pend;
    logic              n_emit;
    logic              skip;

    // stage-one registers (ram read in flight)
    logic              r1_v, r1_emit, r1_bord, r1_fe;
    logic [ADDR_W-1:0] r1_c;
    logic [23:0]       r1_pix;
    logic [47:0]       rd;
    logic [23:0]       up_q, mid_q;
    logic [ADDR_W-1:0] r_fwd_c;
    logic [47:0]       r_fwd_d;
    logic              r_fwd_v;
    logic [23:0]       r_win [9];

    assign skip   = i_flush && (r_pend == '0);
    assign o_skip = skip;

    // next position and pending count
    always_comb begin
        c0 = r_col; r0 = r_row;
        if (c0 >= i_w) begin
            c0 = '0; r0 = r0 + 12'd1;
        end
        if (r0 >= i_h) begin
            r0 = '0;
        end
        c = c0; r = r0;
        if (c != '0) begin
            oc   = c - 11'd1;
            orow = (r != '0) ? r - 12'd1 : i_h - 12'd1;
        end else begin
            oc   = i_w - 11'd1;
            orow = (r >= 12'd2) ? r - 12'd2 : r + i_h - 12'd2;
        end
        n_col = c + 11'd1; n_row = r;
        if (n_col >= i_w) begin
            n_col = '0;
            n_row = r + 12'd1;
            if (n_row >= i_h) n_row = '0;
        end
        n_emit = 1'b0;
        if (!i_flush) begin
            n_pend = r_pend + 1'b1;
            if (n_pend > PW'(i_w + 11'd1)) begin
                n_pend = PW'(i_w + 11'd1);
                n_emit = 1'b1;
            end
        end else begin
            n_pend = r_pend - 1'b1;
            n_emit = 1'b1;
            if (n_pend == '0) begin
                n_col = '0; n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
            r1_v   <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_acc && !skip;
            if (i_acc && !skip) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_acc && !skip) begin
            r1_c    <= c[ADDR_W-1:0];
            r1_pix  <= i_flush ? 24'd0 : i_pix;
            r1_emit <= n_emit;
            r1_bord <= orow == 12'd0 || orow == i_h - 12'd1 || oc == 11'd0
                       || oc == i_w - 11'd1;
            r1_fe   <= orow == i_h - 12'd1 && oc == i_w - 11'd1;
        end
    end

    // both line stores as one ram entry {upper, middle}
    wf3_line_ram #(.DEPTH(MAX_WIDTH), .DW(48)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_en && r1_v),
        .i_waddr(r1_c),
        .i_wdata({mid_q, r1_pix}),
        .i_re   (i_en && i_acc && !skip),
        .i_raddr(c[ADDR_W-1:0]),
        .o_rdata(rd)
    );

    // forward the last write when the next read hits the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (i_en && i_acc && !skip) begin
            r_fwd_v <= r1_v && (r1_c == c[ADDR_W-1:0]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en && i_acc && !skip) begin
            r_fwd_d <= {mid_q, r1_pix};
        end
    end
    assign up_q  = r_fwd_v ? r_fwd_d[47:24] : rd[47:24];
    assign mid_q = r_fwd_v ? r_fwd_d[23:0]  : rd[23:0];

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else if (i_en && r1_v) begin
            r_win[0] <= r_win[1]; r_win[1] <= r_win[2]; r_win[2] <= up_q;
            r_win[3] <= r_win[4]; r_win[4] <= r_win[5]; r_win[5] <= mid_q;
            r_win[6] <= r_win[7]; r_win[7] <= r_win[8]; r_win[8] <= r1_pix;
        end
    end

    logic r2_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v && r1_emit;
        end
    end
    logic r2_bord, r2_fe;
    always_ff @(posedge i_clk) begin
        if (i_en && r1_v) begin
            r2_bord <= r1_bord;
            r2_fe   <= r1_fe;
        end
    end

    assign o_emit           = r2_v;
    assign o_beat.border    = r2_bord;
    assign o_beat.frame_end = r2_fe;
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_beat.win[PIX_W*k +: PIX_W] = r_win[k];
        end
    end
endmodule

### sv/window_filter_3x3_rgb_core.sv
// top level: 3x3 rgb window filter with configuration registers and output register
//
// channel  dir   beat                                      handshake
// s_in     in    kind, pixel_red/green/blue                valid/ready
// m_out    out   filtered_red/green/blue, frame_end        valid/ready
// s_cfg    in    index, data (63 bits)                     valid/ready
//
// one item per cycle sustained while the output is not stalled; a result passes the
// ram read, window, products, sum and divide stages. the line ram port pair sets the rate.
// synchronous active-low reset clears counters, window and valids; no clearing pass.
// the whole pipe advances only when the output stage can take a beat.
`timescale 1ns / 1ps
module window_filter_3x3_rgb_core
    import wf3_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    wf3_in_if.sink        s_in,
    wf3_out_if.source     m_out,
    wf3_cfg_if.sink       s_cfg
);
    logic [2:0]  r_mode;
    logic [10:0] r_width;
    logic [11:0] r_height;
    logic [62:0] r_smooth, r_sharpen;
    logic [10:0] w_eff;
    logic [11:0] h_eff;
    logic        en, acc, skip, emit;
    t_win_beat   beat;
    logic        p3_v, p4_v, p5_v;
    logic        p3_fe, p4_fe;
    logic [7:0]  f_r, f_g, f_b;
    logic [71:0] w_r, w_g, w_b;
    logic [62:0] taps;

    // configuration registers
    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SMOOTH;
            r_width   <= 11'd640;
            r_height  <= 12'd480;
            r_smooth  <= SMOOTH_RESET;
            r_sharpen <= '0;
        end else if (s_cfg.valid) begin
            case (s_cfg.index)
                REG_MODE:    r_mode    <= s_cfg.data[2:0];
                REG_WIDTH:   r_width   <= s_cfg.data[10:0];
                REG_HEIGHT:  r_height  <= s_cfg.data[11:0];
                REG_SMOOTH:  r_smooth  <= s_cfg.data;
                REG_SHARPEN: r_sharpen <= s_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_eff = (r_width < 11'd3) ? 11'd3 :
                   (r_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_width;
    assign h_eff = (r_height < 12'd3) ? 12'd3 : r_height;
    assign taps  = (r_mode == MODE_SMOOTH) ? r_smooth : r_sharpen;

    // pipe advances when the output register is empty or being drained
    assign en       = !m_out.valid || m_out.ready;
    assign s_in.ready = en;
    assign acc      = s_in.valid && en;

    wf3_window u_win (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_acc  (acc),
        .i_flush(s_in.kind),
        .i_pix  ({s_in.pixel_red, s_in.pixel_green, s_in.pixel_blue}),
        .i_w    (w_eff),
        .i_h    (h_eff),
        .o_skip (skip),
        .o_emit (emit),
        .o_beat (beat)
    );

    // split the window into channels
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_r[8*k +: 8] = beat.win[PIX_W*k + 16 +: 8];
            w_g[8*k +: 8] = beat.win[PIX_W*k + 8  +: 8];
            w_b[8*k +: 8] = beat.win[PIX_W*k      +: 8];
        end
    end

    wf3_filter u_fr (.i_clk(i_clk), .i_en(en), .i_mode(r_mode), .i_taps(taps),
                     .i_border(beat.border), .i_win(w_r), .o_val(f_r));
    wf3_filter u_fg (.i_clk(i_clk), .i_en(en), .i_mode(r_mode), .i_taps(taps),
                     .i_border(beat.border), .i_win(w_g), .o_val(f_g));
    wf3_filter u_fb (.i_clk(i_clk), .i_en(en), .i_mode(r_mode), .i_taps(taps),
                     .i_border(beat.border), .i_win(w_b), .o_val(f_b));

    // valid and frame-end track the two filter stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            p3_v <= 1'b0;
            p4_v <= 1'b0;
            p5_v <= 1'b0;
        end else if (en) begin
            p3_v <= emit;
            p4_v <= p3_v;
            p5_v <= p4_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            p3_fe <= beat.frame_end;
            p4_fe <= p3_fe;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            m_out.filtered_red   <= f_r;
            m_out.filtered_green <= f_g;
            m_out.filtered_blue  <= f_b;
            m_out.frame_end      <= p4_fe;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_out.valid <= 1'b0;
        end else if (en) begin
            m_out.valid <= p4_v;
        end
    end

    // output must hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.filtered_red))
        else $error("output changed while stalled");
    // a skipped flush never sets the stage-one valid
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && skip && en |=> !u_win.r1_v)
        else $error("empty flush entered the pipe");
    // no input taken while the pipe is frozen
    a_frz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> !acc)
        else $error("item accepted during stall");
    // p5 stage mirrors valid pipe
    a_p5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> p5_v == $past(p4_v))
        else $error("valid pipe broken");
endmodule
